// File: src/binary_text_packet_deframer_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the packet deframer
// Clocked checks on aclk, with and without the reset qualifier.
// ---------------------------------------------------------------------------
`ifndef BINARY_TEXT_PACKET_DEFRAMER_TOP_DEFINES_SVH
`define BINARY_TEXT_PACKET_DEFRAMER_TOP_DEFINES_SVH

// check a property while out of reset
`define BTPD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check a property at every clock edge
`define BTPD_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: src/btpd_pkg.sv
// ---------------------------------------------------------------------------
// btpd_pkg
// Types, constants and helpers of the binary/text packet deframer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package btpd_pkg;

    localparam int unsigned DATA_W               = 8;
    localparam int unsigned LEN_W                = 32;
    localparam int unsigned LENGTH_BYTES_DEFAULT = 4;
    localparam int unsigned OUT_TDATA_W          = 16;
    localparam int unsigned OUT_TUSER_W          = 2;

    localparam logic [DATA_W-1:0] START_BYTE_RESET = 8'h24;
    localparam logic [DATA_W-1:0] CH_CR            = 8'h0D;
    localparam logic [DATA_W-1:0] CH_LF            = 8'h0A;

    localparam logic [1:0] TERM_LAST = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEN  = 2'd1,
        PH_PAY  = 2'd2,
        PH_TEXT = 2'd3
    } phase_t;

    // terminator is CR LF CR LF
    function automatic logic [DATA_W-1:0] term_byte(input logic [1:0] idx);
        return idx[0] ? CH_LF : CH_CR;
    endfunction

endpackage

// File: src/binary_text_packet_deframer_top.sv
// ---------------------------------------------------------------------------
// binary_text_packet_deframer_top
// Splits a byte stream into binary length-prefixed and CRLFCRLF text packets.
// ---------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------
//  s_      | in  | s_tvalid / s_tready    | s_tdata: rx_byte
//  m_      | out | m_tvalid / m_tready    | m_tdata, m_tuser, m_tlast
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_data: start_byte
//
//  One item per cycle while m_tready is high, for items giving at most
//  one result; a terminator flush of n results holds the input until it drains.
//  Results pass the result burst register, then the output register.
//  The result burst register is the limit: it drains one result per cycle while m_tready is high.
//  aresetn is synchronous, active low; start_byte returns to 0x24.
//  m_tready low holds the output register, then the burst, then s_tready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_text_packet_deframer_top_defines.svh"

module binary_text_packet_deframer_top
    import btpd_pkg::*;
#(
    parameter int unsigned LENGTH_BYTES = LENGTH_BYTES_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,   // [7:0] rx_byte

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] out_byte, [8] run_end, [15:9] zero
    output logic [OUT_TUSER_W-1:0] m_tuser,   // [0] has_byte, [1] kind_text
    output logic                   m_tlast,   // packet_end

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [DATA_W-1:0]      cfg_data   // start_byte
);

    localparam int unsigned CNT_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
    localparam logic [CNT_W-1:0] SEEN_LAST = CNT_W'(LENGTH_BYTES - 1);

    logic [DATA_W-1:0] start_reg, start_next;
    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  seen_reg, seen_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [1:0]        match_reg, match_next;

    logic              desc_valid_reg, desc_valid_next;
    logic [1:0]        desc_pre_reg, desc_pre_next;
    logic [1:0]        desc_pos_reg, desc_pos_next;
    logic              desc_tail_reg, desc_tail_next;
    logic [DATA_W-1:0] desc_byte_reg, desc_byte_next;
    logic              desc_has_reg, desc_has_next;
    logic              desc_text_reg, desc_text_next;
    logic              desc_pend_reg, desc_pend_next;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_byte_reg, out_byte_next;
    logic              out_has_reg, out_has_next;
    logic              out_text_reg, out_text_next;
    logic              out_pend_reg, out_pend_next;
    logic              out_rend_reg, out_rend_next;

    logic              new_tail;
    logic [1:0]        new_pre;
    logic [DATA_W-1:0] new_byte;
    logic              new_has, new_text, new_pend;

    logic in_acc, out_load, desc_pop, head_last;

    assign cfg_ready = 1'b1;
    assign out_load  = !out_valid_reg || m_tready;
    assign head_last = (desc_pre_reg == 2'd0) || (desc_pre_reg == 2'd1 && !desc_tail_reg);
    assign desc_pop  = desc_valid_reg && out_load;
    assign s_tready  = !desc_valid_reg || (desc_pop && head_last);
    assign in_acc    = s_tvalid && s_tready;

    always_comb begin
        start_next = (cfg_valid && cfg_ready) ? cfg_data : start_reg;
        phase_next = phase_reg;
        seen_next  = seen_reg;
        len_next   = len_reg;
        match_next = match_reg;
        new_pre    = 2'd0;
        new_tail   = 1'b0;
        new_byte   = '0;
        new_has    = 1'b0;
        new_text   = 1'b0;
        new_pend   = 1'b0;
        if (in_acc) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (s_tdata == start_reg) begin
                        phase_next = PH_LEN;
                        seen_next  = '0;
                        len_next   = '0;
                    end else begin
                        phase_next = PH_TEXT;
                        match_next = 2'd0;
                        new_tail   = 1'b1;
                        new_byte   = s_tdata;
                        new_has    = 1'b1;
                        new_text   = 1'b1;
                    end
                end
                PH_LEN: begin
                    len_next = {len_reg[LEN_W-DATA_W-1:0], s_tdata};
                    if (seen_reg == SEEN_LAST) begin
                        seen_next = '0;
                        if (len_next == '0) begin
                            new_tail   = 1'b1;
                            new_pend   = 1'b1;
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next = PH_PAY;
                        end
                    end else begin
                        seen_next = seen_reg + CNT_W'(1);
                    end
                end
                PH_PAY: begin
                    new_tail = 1'b1;
                    new_byte = s_tdata;
                    new_has  = 1'b1;
                    len_next = len_reg - LEN_W'(1);
                    if (len_reg == LEN_W'(1)) begin
                        new_pend   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                PH_TEXT: begin
                    if (s_tdata == term_byte(match_reg)) begin
                        if (match_reg == TERM_LAST) begin
                            new_tail   = 1'b1;
                            new_text   = 1'b1;
                            new_pend   = 1'b1;
                            match_next = 2'd0;
                            phase_next = PH_IDLE;
                        end else begin
                            match_next = match_reg + 2'd1;
                        end
                    end else begin
                        new_pre = match_reg;
                        if (s_tdata == CH_CR) begin
                            match_next = 2'd1;
                        end else begin
                            match_next = 2'd0;
                            new_tail   = 1'b1;
                            new_byte   = s_tdata;
                            new_has    = 1'b1;
                            new_text   = 1'b1;
                        end
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        desc_valid_next = desc_valid_reg;
        desc_pre_next   = desc_pre_reg;
        desc_pos_next   = desc_pos_reg;
        desc_tail_next  = desc_tail_reg;
        desc_byte_next  = desc_byte_reg;
        desc_has_next   = desc_has_reg;
        desc_text_next  = desc_text_reg;
        desc_pend_next  = desc_pend_reg;
        if (in_acc && (new_pre != 2'd0 || new_tail)) begin
            desc_valid_next = 1'b1;
            desc_pre_next   = new_pre;
            desc_pos_next   = 2'd0;
            desc_tail_next  = new_tail;
            desc_byte_next  = new_byte;
            desc_has_next   = new_has;
            desc_text_next  = new_text;
            desc_pend_next  = new_pend;
        end else if (desc_pop) begin
            if (head_last) begin
                desc_valid_next = 1'b0;
            end else begin
                desc_pre_next = desc_pre_reg - 2'd1;
                desc_pos_next = desc_pos_reg + 2'd1;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_has_next   = out_has_reg;
        out_text_next  = out_text_reg;
        out_pend_next  = out_pend_reg;
        out_rend_next  = out_rend_reg;
        if (out_load) begin
            out_valid_next = desc_valid_reg;
            if (desc_pre_reg != 2'd0) begin
                out_byte_next = term_byte(desc_pos_reg);
                out_has_next  = 1'b1;
                out_text_next = 1'b1;
                out_pend_next = 1'b0;
                out_rend_next = head_last;
            end else begin
                out_byte_next = desc_byte_reg;
                out_has_next  = desc_has_reg;
                out_text_next = desc_text_reg;
                out_pend_next = desc_pend_reg;
                out_rend_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg      <= START_BYTE_RESET;
            phase_reg      <= PH_IDLE;
            seen_reg       <= '0;
            len_reg        <= '0;
            match_reg      <= 2'd0;
            desc_valid_reg <= 1'b0;
            desc_pre_reg   <= 2'd0;
            desc_tail_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            start_reg      <= start_next;
            phase_reg      <= phase_next;
            seen_reg       <= seen_next;
            len_reg        <= len_next;
            match_reg      <= match_next;
            desc_valid_reg <= desc_valid_next;
            desc_pre_reg   <= desc_pre_next;
            desc_tail_reg  <= desc_tail_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_pos_reg  <= desc_pos_next;
        desc_byte_reg <= desc_byte_next;
        desc_has_reg  <= desc_has_next;
        desc_text_reg <= desc_text_next;
        desc_pend_reg <= desc_pend_next;
        out_byte_reg  <= out_byte_next;
        out_has_reg   <= out_has_next;
        out_text_reg  <= out_text_next;
        out_pend_reg  <= out_pend_next;
        out_rend_reg  <= out_rend_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-DATA_W-1){1'b0}}, out_rend_reg, out_byte_reg};
    assign m_tuser  = {out_text_reg, out_has_reg};
    assign m_tlast  = out_pend_reg;

    `BTPD_ASSERT_RST(a_hold_input_on_stall,
        desc_valid_reg && m_tvalid && !m_tready |-> !s_tready,
        "input taken while result burst is stalled")
    `BTPD_ASSERT_RST(a_burst_not_empty,
        desc_valid_reg |-> (desc_pre_reg != 2'd0 || desc_tail_reg),
        "empty result burst held")
    `BTPD_ASSERT_RST(a_marker_clean,
        m_tvalid && !m_tuser[0] |-> (m_tdata[7:0] == '0 && m_tlast),
        "end marker without packet end or with data")
    `BTPD_ASSERT_RST(a_packet_end_ends_run,
        m_tvalid && m_tlast |-> m_tdata[8],
        "packet end not on last result of its item")

endmodule
